FILE: design/ipfwd_pkg.sv
// Shared types, constants and a helper function for the IPv4 forwarding decision block.
`default_nettype none

package ipfwd_pkg;

    // Route table geometry
    localparam int NUM_ROUTES = 32;
    localparam int IDX_W      = (NUM_ROUTES > 1) ? $clog2(NUM_ROUTES) : 1;
    localparam int CNT_W      = $clog2(NUM_ROUTES + 1);
    localparam int NUM_LOCAL  = 4;
    localparam int PLEN_W     = 6;

    localparam logic [3:0] IP_VERSION_4   = 4'd4;
    localparam logic [7:0] PROTO_RESET    = 8'd89;

    // Configuration register indexes
    localparam logic [2:0] CFG_LOCAL_A     = 3'd0;
    localparam logic [2:0] CFG_LOCAL_B     = 3'd1;
    localparam logic [2:0] CFG_LOCAL_C     = 3'd2;
    localparam logic [2:0] CFG_LOCAL_D     = 3'd3;
    localparam logic [2:0] CFG_LOCAL_EN    = 3'd4;
    localparam logic [2:0] CFG_ROUTE_PROTO = 3'd5;

    typedef enum logic [2:0] {
        V_FORWARD     = 3'd0,
        V_BAD_VERSION = 3'd1,
        V_BAD_CSUM    = 3'd2,
        V_TTL_EXPIRED = 3'd3,
        V_ROUTE_PROTO = 3'd4,
        V_LOCAL       = 3'd5,
        V_NO_ROUTE    = 3'd6,
        V_WRITTEN     = 3'd7
    } verdict_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic        mode;
        logic [4:0]  entry_index;
        logic        entry_valid;
        logic [31:0] entry_dest;
        logic [31:0] entry_mask;
        logic [31:0] entry_gateway;
        logic [1:0]  entry_port;
        logic [31:0] dest_ip;
        logic [3:0]  ip_version;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic        checksum_ok;
    } in_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] next_hop_ip;
        logic [1:0]  out_port;
        logic [7:0]  new_ttl;
        logic        used_default;
    } out_t;

    typedef struct packed {
        logic [NUM_LOCAL-1:0][31:0] local_ip;
        logic [NUM_LOCAL-1:0]       local_en;
        logic [7:0]                 route_proto;
    } cfg_t;

    // One route table row as stored in memory
    typedef struct packed {
        logic [31:0]       dest;
        logic [31:0]       mask;
        logic [31:0]       gateway;
        logic [1:0]        port;
        logic [PLEN_W-1:0] plen;
    } route_entry_t;

    // Route memory control
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             wr_valid;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_ctl_t;

    // Count of consecutive ones from bit 31 down, by a five-step binary search
    function automatic logic [PLEN_W-1:0] prefix_len(input logic [31:0] mask);
        logic [31:0]       m;
        logic [31:0]       top;
        logic [PLEN_W-1:0] n;
        m = mask;
        n = '0;
        if (&mask)
        begin
            n = PLEN_W'(32);
        end
        else
        begin
            for (int s = 4; s >= 0; s--)
            begin
                top = ~(32'hFFFF_FFFF >> (1 << s));
                if ((m & top) == top)
                begin
                    m = m << (1 << s);
                    n = n + PLEN_W'(1 << s);
                end
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: design/ipfwd_route_mem.sv
// Route table storage: synchronous memory for route rows plus per-slot valid flops.
`default_nettype none

module ipfwd_route_mem
    import ipfwd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire mem_ctl_t     ctl,
    input  wire route_entry_t wr_data,
    output route_entry_t      rd_data,
    output logic              rd_valid
);

    route_entry_t            route_mem [NUM_ROUTES];
    route_entry_t            rd_data_reg;
    logic [NUM_ROUTES-1:0]   valid_reg;
    logic                    rd_valid_reg;

    // Row storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            route_mem[ctl.wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= route_mem[ctl.rd_addr];
        end
    end

    // Slot valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[ctl.wr_addr] <= ctl.wr_valid;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctl.rd_addr];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

FILE: design/ipfwd_lpm_ctrl.sv
// Sequencer: header checks, route table writes and the longest-prefix scan.
`default_nettype none

module ipfwd_lpm_ctrl
    import ipfwd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire in_t          in_data,
    output logic              in_stall,
    input  wire cfg_t         cfg,
    output logic              res_valid,
    input  wire logic         res_ready,
    output out_t              res,
    output mem_ctl_t          mem_ctl,
    output route_entry_t      wr_entry,
    input  wire route_entry_t rd_entry,
    input  wire logic         rd_entry_valid
);

    state_t            state_reg, state_next;
    in_t               hdr_reg, hdr_next;
    verdict_t          verdict_reg, verdict_next;
    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              rd_last_reg, rd_last_next;
    logic              have_match_reg, have_match_next;
    logic              have_def_reg, have_def_next;
    logic [PLEN_W-1:0] best_len_reg, best_len_next;
    logic [31:0]       match_gw_reg, match_gw_next;
    logic [1:0]        match_port_reg, match_port_next;
    logic [31:0]       def_gw_reg, def_gw_next;
    logic [1:0]        def_port_reg, def_port_next;

    logic              local_hit;
    logic              wr_ok;
    logic              entry_hit;

    // Local interface address match
    always_comb
    begin
        local_hit = 1'b0;
        for (int i = 0; i < NUM_LOCAL; i++)
        begin
            if (cfg.local_en[i] && (cfg.local_ip[i] == hdr_reg.dest_ip))
            begin
                local_hit = 1'b1;
            end
        end
    end

    // Slot range test of a write index, and prefix test of the row returned from memory
    assign wr_ok     = (32'(in_data.entry_index) < 32'(NUM_ROUTES));
    assign entry_hit = ((hdr_reg.dest_ip & rd_entry.mask) == (rd_entry.dest & rd_entry.mask));

    // Row written on a write transfer, prefix length stored with it
    always_comb
    begin
        wr_entry.dest    = in_data.entry_dest;
        wr_entry.mask    = in_data.entry_mask;
        wr_entry.gateway = in_data.entry_gateway;
        wr_entry.port    = in_data.entry_port;
        wr_entry.plen    = prefix_len(in_data.entry_mask);
    end

    // Next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        hdr_next        = hdr_reg;
        verdict_next    = verdict_reg;
        issue_cnt_next  = issue_cnt_reg;
        have_match_next = have_match_reg;
        have_def_next   = have_def_reg;
        best_len_next   = best_len_reg;
        match_gw_next   = match_gw_reg;
        match_port_next = match_port_reg;
        def_gw_next     = def_gw_reg;
        def_port_next   = def_port_reg;
        rd_vld_next     = 1'b0;
        rd_last_next    = 1'b0;
        in_stall        = 1'b1;
        res_valid       = 1'b0;
        mem_ctl         = '0;
        mem_ctl.wr_addr = IDX_W'(in_data.entry_index);
        mem_ctl.wr_valid = in_data.entry_valid;
        mem_ctl.rd_addr = issue_cnt_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (!in_data.mode)
                    begin
                        mem_ctl.wr_en = wr_ok;
                        verdict_next  = V_WRITTEN;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        hdr_next        = in_data;
                        have_match_next = 1'b0;
                        have_def_next   = 1'b0;
                        best_len_next   = '0;
                        state_next      = S_CHECK;
                    end
                end
            end

            // Header checks in priority order
            S_CHECK:
            begin
                state_next = S_FINISH;
                if (hdr_reg.ip_version != IP_VERSION_4)
                begin
                    verdict_next = V_BAD_VERSION;
                end
                else if (!hdr_reg.checksum_ok)
                begin
                    verdict_next = V_BAD_CSUM;
                end
                else if (hdr_reg.ttl <= 8'd1)
                begin
                    verdict_next = V_TTL_EXPIRED;
                end
                else if (hdr_reg.protocol == cfg.route_proto)
                begin
                    verdict_next = V_ROUTE_PROTO;
                end
                else if (local_hit)
                begin
                    verdict_next = V_LOCAL;
                end
                else
                begin
                    verdict_next   = V_FORWARD;
                    issue_cnt_next = '0;
                    state_next     = S_SCAN;
                end
            end

            // Issue one read a cycle, evaluate each row in the cycle after its read is issued
            S_SCAN:
            begin
                if (issue_cnt_reg < CNT_W'(NUM_ROUTES))
                begin
                    mem_ctl.rd_en  = 1'b1;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    rd_vld_next    = 1'b1;
                    rd_last_next   = (issue_cnt_reg == CNT_W'(NUM_ROUTES - 1));
                end
                if (rd_vld_reg && rd_entry_valid)
                begin
                    if (rd_entry.dest == 32'd0)
                    begin
                        // default route: last valid one wins
                        have_def_next = 1'b1;
                        def_gw_next   = rd_entry.gateway;
                        def_port_next = rd_entry.port;
                    end
                    else if (entry_hit && (!have_match_reg || (rd_entry.plen > best_len_reg)))
                    begin
                        have_match_next = 1'b1;
                        best_len_next   = rd_entry.plen;
                        match_gw_next   = rd_entry.gateway;
                        match_port_next = rd_entry.port;
                    end
                end
                if (rd_vld_reg && rd_last_reg)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result assembly
    always_comb
    begin
        res         = '0;
        res.verdict = verdict_reg;
        if (verdict_reg == V_FORWARD)
        begin
            if (have_match_reg)
            begin
                res.next_hop_ip = (match_gw_reg != 32'd0) ? match_gw_reg : hdr_reg.dest_ip;
                res.out_port    = match_port_reg;
                res.new_ttl     = hdr_reg.ttl - 8'd1;
            end
            else if (have_def_reg)
            begin
                res.next_hop_ip  = (def_gw_reg != 32'd0) ? def_gw_reg : hdr_reg.dest_ip;
                res.out_port     = def_port_reg;
                res.new_ttl      = hdr_reg.ttl - 8'd1;
                res.used_default = 1'b1;
            end
            else
            begin
                res.verdict = V_NO_ROUTE;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            verdict_reg    <= V_WRITTEN;
            issue_cnt_reg  <= '0;
            rd_vld_reg     <= 1'b0;
            rd_last_reg    <= 1'b0;
            have_match_reg <= 1'b0;
            have_def_reg   <= 1'b0;
            best_len_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            verdict_reg    <= verdict_next;
            issue_cnt_reg  <= issue_cnt_next;
            rd_vld_reg     <= rd_vld_next;
            rd_last_reg    <= rd_last_next;
            have_match_reg <= have_match_next;
            have_def_reg   <= have_def_next;
            best_len_reg   <= best_len_next;
        end
    end

    // Header and best-route payload
    always_ff @(posedge clk)
    begin
        hdr_reg        <= hdr_next;
        match_gw_reg   <= match_gw_next;
        match_port_reg <= match_port_next;
        def_gw_reg     <= def_gw_next;
        def_port_reg   <= def_port_next;
    end

    // The last evaluated row ends the scan
    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && rd_vld_reg && rd_last_reg) |=> (state_reg == S_FINISH))
        else $error("scan did not finish after the last row");

    // Checks either end the item or start the scan
    a_check_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |=> (state_reg == S_SCAN || state_reg == S_FINISH))
        else $error("bad exit from header check");

    // A forwarded result comes from a found route with a live TTL
    a_fwd_route: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.verdict == V_FORWARD)
            |-> ((have_match_reg || have_def_reg) && res.new_ttl != 8'd0))
        else $error("forward verdict without a route");

    // Any other verdict carries zero fields
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.verdict != V_FORWARD)
            |-> (res.next_hop_ip == 32'd0 && res.out_port == 2'd0
                 && res.new_ttl == 8'd0 && !res.used_default))
        else $error("non-forward result has nonzero fields");

    // No table write while a scan reads the memory
    a_no_wr_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_vld_reg) |-> !mem_ctl.wr_en)
        else $error("route write overlaps a scan");

endmodule

`default_nettype wire

FILE: design/ipv4_forward_lpm_decision.sv
// Flow: a route write goes from idle to the finish state; a header that fails a check passes
// the check state first; a full lookup then walks every slot in the scan state before finish.
// Items are taken one at a time; a full lookup is paced by the single read port of the route
// memory, walked one slot per cycle while the scan runs.
// Reset clears all slot valid bits, the local addresses and enables; routing protocol is 89.
// The output register lets the next item be taken while a result waits for transfer.
`default_nettype none

module ipv4_forward_lpm_decision
    import ipfwd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t          cfg_reg;
    logic          out_valid_reg;
    out_t          out_data_reg;

    logic          res_valid;
    logic          res_ready;
    out_t          res;
    mem_ctl_t      mem_ctl;
    route_entry_t  wr_entry;
    route_entry_t  rd_entry;
    logic          rd_entry_valid;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.local_ip    <= '0;
            cfg_reg.local_en    <= '0;
            cfg_reg.route_proto <= PROTO_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LOCAL_A:     cfg_reg.local_ip[0] <= cfg_data;
                CFG_LOCAL_B:     cfg_reg.local_ip[1] <= cfg_data;
                CFG_LOCAL_C:     cfg_reg.local_ip[2] <= cfg_data;
                CFG_LOCAL_D:     cfg_reg.local_ip[3] <= cfg_data;
                CFG_LOCAL_EN:    cfg_reg.local_en    <= cfg_data[NUM_LOCAL-1:0];
                CFG_ROUTE_PROTO: cfg_reg.route_proto <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    ipfwd_lpm_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_data        (in_data),
        .in_stall       (in_stall),
        .cfg            (cfg_reg),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .mem_ctl        (mem_ctl),
        .wr_entry       (wr_entry),
        .rd_entry       (rd_entry),
        .rd_entry_valid (rd_entry_valid)
    );

    ipfwd_route_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mem_ctl),
        .wr_data  (wr_entry),
        .rd_data  (rd_entry),
        .rd_valid (rd_entry_valid)
    );

    // Output register
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: tb/tb_ipv4_forward_lpm_decision.sv
`timescale 1ns / 100ps
// Self-checking testbench for the IPv4 forwarding decision block with longest-prefix lookup.
module tb_ipv4_forward_lpm_decision;
    import ipfwd_pkg::*;

    localparam int      CLK_HALF     = 4;
    localparam int      RESET_CYCLES = 9;
    localparam int      PHASE_ITEMS  = 400;
    localparam int      TAIL_CYCLES  = 2 * (NUM_ROUTES + 4);
    localparam longint  LIMIT_NS     = 64'd8_000_000;

    localparam logic       MODE_WRITE = 1'b0;
    localparam logic       MODE_ROUTE = 1'b1;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_t         in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = CFG_LOCAL_A;
    logic [31:0] cfg_data  = '0;

    // Shadow of the route table and registers, as the block should hold them
    logic                 rt_valid   [NUM_ROUTES];
    logic [31:0]          rt_dest    [NUM_ROUTES];
    logic [31:0]          rt_mask    [NUM_ROUTES];
    logic [31:0]          rt_gateway [NUM_ROUTES];
    logic [1:0]           rt_port    [NUM_ROUTES];
    logic [31:0]          cur_local_ip [NUM_LOCAL];
    logic [NUM_LOCAL-1:0] cur_local_en;
    logic [7:0]           cur_route_proto;

    // Generator's view of the table, used to aim lookups at installed prefixes
    logic        gen_valid [NUM_ROUTES];
    logic [31:0] gen_dest  [NUM_ROUTES];
    logic [31:0] gen_mask  [NUM_ROUTES];

    in_t  items_to_send[$];
    out_t expected_decisions[$];
    out_t want_dec;
    logic in_fire;
    int   send_idle_pct;
    int   stall_pct;
    int   bad_count;

    ipv4_forward_lpm_decision uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Number of consecutive ones from bit 31 down
    function automatic int unsigned lead_ones(logic [31:0] m);
        int unsigned n;
        n = 0;
        while (n < 32 && m[31 - n])
        begin
            n++;
        end
        return n;
    endfunction

    // Expected decision for one transfer; route writes update the shadow table
    function automatic out_t forward_decision(in_t it);
        out_t        r;
        logic        is_local;
        logic        have_def;
        logic        have_hit;
        int unsigned def_slot;
        int unsigned hit_slot;
        int unsigned best_len;
        int unsigned plen;
        int unsigned slot;
        r        = '0;
        is_local = 1'b0;
        have_def = 1'b0;
        have_hit = 1'b0;
        def_slot = 0;
        hit_slot = 0;
        best_len = 0;
        if (it.mode == MODE_WRITE)
        begin
            if (it.entry_index < NUM_ROUTES)
            begin
                rt_valid[it.entry_index]   = it.entry_valid;
                rt_dest[it.entry_index]    = it.entry_dest;
                rt_mask[it.entry_index]    = it.entry_mask;
                rt_gateway[it.entry_index] = it.entry_gateway;
                rt_port[it.entry_index]    = it.entry_port;
            end
            r.verdict = V_WRITTEN;
            return r;
        end
        for (int i = 0; i < NUM_LOCAL; i++)
        begin
            if (cur_local_en[i] && cur_local_ip[i] == it.dest_ip)
            begin
                is_local = 1'b1;
            end
        end
        // header checks in priority order
        if (it.ip_version != IP_VERSION_4)
            r.verdict = V_BAD_VERSION;
        else if (!it.checksum_ok)
            r.verdict = V_BAD_CSUM;
        else if (it.ttl <= 8'd1)
            r.verdict = V_TTL_EXPIRED;
        else if (it.protocol == cur_route_proto)
            r.verdict = V_ROUTE_PROTO;
        else if (is_local)
            r.verdict = V_LOCAL;
        else
        begin
            // walk the table: last default wins, longest prefix wins, ties keep the first
            for (int i = 0; i < NUM_ROUTES; i++)
            begin
                if (rt_valid[i])
                begin
                    if (rt_dest[i] == 32'd0)
                    begin
                        have_def = 1'b1;
                        def_slot = i;
                    end
                    else if ((it.dest_ip & rt_mask[i]) == (rt_dest[i] & rt_mask[i]))
                    begin
                        plen = lead_ones(rt_mask[i]);
                        if (!have_hit || plen > best_len)
                        begin
                            have_hit = 1'b1;
                            hit_slot = i;
                            best_len = plen;
                        end
                    end
                end
            end
            if (have_hit || have_def)
            begin
                slot           = have_hit ? hit_slot : def_slot;
                r.verdict      = V_FORWARD;
                r.next_hop_ip  = (rt_gateway[slot] != 32'd0) ? rt_gateway[slot] : it.dest_ip;
                r.out_port     = rt_port[slot];
                r.new_ttl      = it.ttl - 8'd1;
                r.used_default = !have_hit;
            end
            else
                r.verdict = V_NO_ROUTE;
        end
        return r;
    endfunction

    // Random bits in every field, so unused fields toggle too
    function automatic in_t scrambled();
        logic [159:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        return raw[$bits(in_t)-1:0];
    endfunction

    function automatic in_t hdr(logic [31:0] dst, logic [3:0] ver, logic [7:0] ttl,
                                logic [7:0] proto, logic ok);
        in_t it;
        it             = scrambled();
        it.mode        = MODE_ROUTE;
        it.dest_ip     = dst;
        it.ip_version  = ver;
        it.ttl         = ttl;
        it.protocol    = proto;
        it.checksum_ok = ok;
        return it;
    endfunction

    function automatic in_t route_wr(logic [4:0] idx, logic vld, logic [31:0] dest,
                                     logic [31:0] mask, logic [31:0] gw, logic [1:0] port);
        in_t it;
        it               = scrambled();
        it.mode          = MODE_WRITE;
        it.entry_index   = idx;
        it.entry_valid   = vld;
        it.entry_dest    = dest;
        it.entry_mask    = mask;
        it.entry_gateway = gw;
        it.entry_port    = port;
        gen_valid[idx]   = vld;
        gen_dest[idx]    = dest;
        gen_mask[idx]    = mask;
        return it;
    endfunction

    // Addresses clustered in a few first octets so prefixes overlap
    function automatic logic [31:0] pool_addr();
        logic [7:0] octet;
        case ($urandom_range(3))
            0: octet = 8'd10;
            1: octet = 8'd172;
            2: octet = 8'd192;
            default: octet = 8'($urandom());
        endcase
        return {octet, 24'($urandom())};
    endfunction

    function automatic in_t random_item();
        int unsigned pick;
        int unsigned slot;
        logic [31:0] mask;
        logic [31:0] dst;
        logic [7:0]  proto;
        pick = $urandom_range(99);
        if (pick < 22)
        begin
            // route write: mostly contiguous masks, some defaults, some removals
            if ($urandom_range(9) == 0)
                mask = $urandom();
            else
                mask = 32'hFFFF_FFFF << (32 - $urandom_range(32));
            dst = ($urandom_range(9) == 0) ? 32'd0 : (pool_addr() & mask);
            return route_wr(5'($urandom_range(NUM_ROUTES - 1)), $urandom_range(99) < 85, dst,
                            mask, ($urandom_range(1) == 0) ? 32'd0 : $urandom(),
                            2'($urandom_range(3)));
        end
        else if (pick < 80)
        begin
            // well-formed header aimed at an installed prefix or a local address
            dst  = pool_addr();
            slot = $urandom_range(NUM_ROUTES - 1);
            for (int k = 0; k < 8 && !gen_valid[slot]; k++)
            begin
                slot = $urandom_range(NUM_ROUTES - 1);
            end
            if ($urandom_range(9) == 0)
                dst = cur_local_ip[$urandom_range(NUM_LOCAL - 1)];
            else if ($urandom_range(9) < 8 && gen_valid[slot])
                dst = (gen_dest[slot] & gen_mask[slot]) | ($urandom() & ~gen_mask[slot]);
            proto = 8'($urandom());
            if (proto == cur_route_proto)
                proto = proto + 8'd1;
            return hdr(dst, IP_VERSION_4, 8'($urandom_range(255, 2)), proto, 1'b1);
        end
        // broken headers
        return hdr(pool_addr(), ($urandom_range(1) == 0) ? IP_VERSION_4 : 4'($urandom()),
                   ($urandom_range(1) == 0) ? 8'($urandom_range(2)) : 8'($urandom()),
                   ($urandom_range(2) == 0) ? cur_route_proto : 8'($urandom()),
                   1'($urandom_range(3) != 0));
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_LOCAL_A, CFG_LOCAL_B, CFG_LOCAL_C, CFG_LOCAL_D: cur_local_ip[idx] = val;
            CFG_LOCAL_EN:    cur_local_en    = val[NUM_LOCAL-1:0];
            CFG_ROUTE_PROTO: cur_route_proto = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_until_drained();
        @(posedge clk);
        while (items_to_send.size() != 0 || in_valid || expected_decisions.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Input driver: new transfer offered at the falling edge once the last one went through
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= items_to_send.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: predict on input transfers, check on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                expected_decisions.push_back(forward_decision(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_decisions.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: unexpected result, verdict %0d", $time, out_data.verdict);
                end
                else
                begin
                    want_dec = expected_decisions.pop_front();
                    if (out_data.verdict !== want_dec.verdict
                        || out_data.next_hop_ip !== want_dec.next_hop_ip
                        || out_data.out_port !== want_dec.out_port
                        || out_data.new_ttl !== want_dec.new_ttl
                        || out_data.used_default !== want_dec.used_default)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display("%0t: exp v%0d hop %h port %0d ttl %0d dflt %b, got v%0d hop %h port %0d ttl %0d dflt %b",
                                     $time, want_dec.verdict, want_dec.next_hop_ip,
                                     want_dec.out_port, want_dec.new_ttl, want_dec.used_default,
                                     out_data.verdict, out_data.next_hop_ip, out_data.out_port,
                                     out_data.new_ttl, out_data.used_default);
                    end
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #(LIMIT_NS);
        $display("FAIL ipv4_forward_lpm_decision");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < NUM_ROUTES; i++)
        begin
            rt_valid[i]   = 1'b0;
            rt_dest[i]    = '0;
            rt_mask[i]    = '0;
            rt_gateway[i] = '0;
            rt_port[i]    = '0;
            gen_valid[i]  = 1'b0;
            gen_dest[i]   = '0;
            gen_mask[i]   = '0;
        end
        for (int i = 0; i < NUM_LOCAL; i++)
        begin
            cur_local_ip[i] = '0;
        end
        cur_local_en    = '0;
        cur_route_proto = PROTO_RESET;
        send_idle_pct   = 0;
        stall_pct       = 0;
        bad_count       = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: interface 0 and 1 addresses live, 2 and 3 set but disabled
        write_reg(CFG_LOCAL_A, 32'hC0A8_0101);
        write_reg(CFG_LOCAL_B, 32'h0A00_0001);
        write_reg(CFG_LOCAL_C, 32'hFFFF_FFFF);
        write_reg(CFG_LOCAL_D, 32'h0000_0000);
        write_reg(CFG_LOCAL_EN, 32'h3);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);

        items_to_send.push_back(hdr(32'h0B00_0001, IP_VERSION_4, 8'd64, 8'd6, 1'b1));
        items_to_send.push_back(hdr(32'h0B00_0001, 4'd0, 8'd64, 8'd6, 1'b1));
        items_to_send.push_back(hdr(32'h0B00_0001, 4'd15, 8'd64, 8'd6, 1'b1));
        items_to_send.push_back(hdr(32'h0B00_0001, 4'd6, 8'd0, PROTO_RESET, 1'b0));
        items_to_send.push_back(hdr(32'h0B00_0001, IP_VERSION_4, 8'd1, PROTO_RESET, 1'b0));
        items_to_send.push_back(hdr(32'h0B00_0001, IP_VERSION_4, 8'd1, 8'd6, 1'b1));
        items_to_send.push_back(hdr(32'h0B00_0001, IP_VERSION_4, 8'd0, PROTO_RESET, 1'b1));
        items_to_send.push_back(hdr(32'hC0A8_0101, IP_VERSION_4, 8'd64, PROTO_RESET, 1'b1));
        items_to_send.push_back(hdr(32'hC0A8_0101, IP_VERSION_4, 8'd64, 8'd17, 1'b1));
        items_to_send.push_back(hdr(32'hFFFF_FFFF, IP_VERSION_4, 8'd64, 8'd17, 1'b1));
        // two defaults (the later one wins), nested prefixes, a tie, odd masks, a host route
        items_to_send.push_back(route_wr(5'd0, 1'b1, 32'd0, 32'd0, 32'hC0A8_0001, 2'd1));
        items_to_send.push_back(route_wr(5'd31, 1'b1, 32'd0, 32'd0, 32'd0, 2'd3));
        items_to_send.push_back(route_wr(5'd1, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'd0, 2'd2));
        items_to_send.push_back(route_wr(5'd2, 1'b1, 32'h0A01_0000, 32'hFFFF_0000,
                                         32'h0A00_00FE, 2'd3));
        items_to_send.push_back(route_wr(5'd3, 1'b1, 32'h0A01_0000, 32'hFFFF_0000,
                                         32'h0A00_00FD, 2'd0));
        items_to_send.push_back(route_wr(5'd4, 1'b1, 32'hAC10_0000, 32'hFF00_FF00,
                                         32'hFFFF_FFFF, 2'd1));
        items_to_send.push_back(route_wr(5'd5, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 2'd2));
        items_to_send.push_back(hdr(32'h0A01_0203, IP_VERSION_4, 8'd255, 8'd17, 1'b1));
        items_to_send.push_back(hdr(32'h0A02_0304, IP_VERSION_4, 8'd2, 8'd17, 1'b1));
        items_to_send.push_back(hdr(32'h0B00_0001, IP_VERSION_4, 8'd64, 8'd17, 1'b1));
        items_to_send.push_back(hdr(32'hFFFF_FFFF, IP_VERSION_4, 8'd64, 8'd17, 1'b1));
        items_to_send.push_back(hdr(32'hAC33_00AA, IP_VERSION_4, 8'd64, 8'd17, 1'b1));
        items_to_send.push_back(route_wr(5'd31, 1'b0, 32'd0, 32'd0, 32'd0, 2'd0));
        items_to_send.push_back(hdr(32'h0B00_0001, IP_VERSION_4, 8'd64, 8'd17, 1'b1));
        // zero-length prefix with nonzero destination still beats the default
        items_to_send.push_back(route_wr(5'd6, 1'b1, 32'h0102_0304, 32'd0, 32'h0101_0101, 2'd0));
        items_to_send.push_back(hdr(32'h0B00_0001, IP_VERSION_4, 8'd64, 8'd17, 1'b1));
        wait_until_drained();

        // Random phases, registers changed only while nothing is in flight
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1:
                begin
                    write_reg(CFG_LOCAL_A, $urandom());
                    write_reg(CFG_LOCAL_B, $urandom());
                    write_reg(CFG_LOCAL_C, pool_addr());
                    write_reg(CFG_LOCAL_D, pool_addr());
                    write_reg(CFG_LOCAL_EN, 32'hF);
                    write_reg(CFG_ROUTE_PROTO, 32'hFF);
                    send_idle_pct = 82;
                    stall_pct     = 0;
                end
                2:
                begin
                    write_reg(CFG_LOCAL_A, 32'h0000_0000);
                    write_reg(CFG_LOCAL_B, 32'hFFFF_FFFF);
                    write_reg(CFG_LOCAL_EN, 32'h0);
                    write_reg(CFG_ROUTE_PROTO, 32'h0);
                    send_idle_pct = 0;
                    stall_pct     = 82;
                end
                3:
                begin
                    write_reg(CFG_LOCAL_A, pool_addr());
                    write_reg(CFG_LOCAL_D, 32'h0A01_0203);
                    write_reg(CFG_LOCAL_EN, $urandom_range(14, 1));
                    write_reg(CFG_ROUTE_PROTO, PROTO_RESET);
                    send_idle_pct = 16;
                    stall_pct     = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            repeat (PHASE_ITEMS) items_to_send.push_back(random_item());
            wait_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (bad_count == 0 && expected_decisions.size() == 0)
            $display("PASS ipv4_forward_lpm_decision");
        else
            $display("FAIL ipv4_forward_lpm_decision");
        $finish;
    end

endmodule
